[hw/rtl/mrff_pkg.sv]
// ----------------------------------------------------------------------------
// mrff_pkg
// Shared types and constants of the Modbus RTU response frame finder:
// operation codes, register indexes, frame sizing constants and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mrff_pkg;

    // operation carried in tuser of the request channel
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_EXP_FUNC   = 2'd1;

    // reset values of the configuration registers
    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
    localparam logic [7:0] EXP_FUNC_RST   = 8'h03;

    // function codes and frame sizing
    localparam logic [7:0] FN_READ        = 8'h03;
    localparam logic [7:0] FN_WRITE       = 8'h10;
    localparam logic [7:0] FN_EXC_BIT     = 8'h80;
    localparam logic [7:0] ADDR_FALLBACK  = 8'd1;
    localparam logic [8:0] MIN_FRAME_LEN  = 9'd5;
    localparam logic [8:0] READ_OVERHEAD  = 9'd5;
    localparam logic [8:0] WRITE_LEN      = 9'd8;
    localparam logic [8:0] EXC_LEN        = 9'd5;

    // which buffer position a read looks at, relative to the head
    typedef enum logic [1:0] {
        RD_HEAD  = 2'd0,
        RD_FUNC  = 2'd1,
        RD_COUNT = 2'd2,
        RD_INDEX = 2'd3
    } t_rd_sel;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_TOP,
        ST_SRCH_CHK,
        ST_GET_FN,
        ST_GET_CNT,
        ST_RD_WAIT,
        ST_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    push;
        logic    clear;
        logic    drop;
        logic    set_frame;
        logic    cap_fn;
        logic    cap_data;
        logic    zero_data;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic can_push;
        logic read_ok;
        logic fill_lt_min;
        logic fill_is_one;
        logic byte_match;
        logic size_zero;
        logic fill_lt_size;
        logic out_free;
    } t_dp_status;

endpackage

[hw/rtl/mrff_ram.sv]
// ----------------------------------------------------------------------------
// mrff_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mrff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/mrff_dpath.sv]
// ----------------------------------------------------------------------------
// mrff_dpath
// Datapath of the frame finder: circular byte buffer with head pointer and
// fill count, configuration registers, frame sizing, held frame status and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module mrff_dpath
    import mrff_pkg::*;
#(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_wr,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // request fields
    input  logic [7:0]  i_rx_byte,
    input  logic [8:0]  i_read_index,
    // controller interface
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_done,
    output logic        o_frame_kind,
    output logic [8:0]  o_frame_length,
    output logic [7:0]  o_read_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    r_slave_addr;
    logic [7:0]    r_exp_func;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_done;
    logic [8:0]    r_len;
    logic          r_kind;
    logic [7:0]    r_fn;
    logic [7:0]    r_data;
    logic          r_out_valid;
    logic          r_out_done;
    logic          r_out_kind;
    logic [8:0]    r_out_len;
    logic [7:0]    r_out_data;

    logic [CW-1:0] rd_off;
    logic [CW:0]   rd_sum;
    logic [CW:0]   wr_sum;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    ram_rdata;
    logic [7:0]    match_addr;
    logic [8:0]    size;
    logic          size_kind;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RST;
            r_exp_func   <= EXP_FUNC_RST;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == REG_SLAVE_ADDR) begin
                r_slave_addr <= i_cfg_data;
            end
            if (i_cfg_index == REG_EXP_FUNC) begin
                r_exp_func <= i_cfg_data;
            end
        end
    end

    // address zero stands for address one
    assign match_addr = (r_slave_addr == '0) ? ADDR_FALLBACK : r_slave_addr;

    // read position relative to the head, wrapped into the buffer
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_HEAD:  rd_off = '0;
            RD_FUNC:  rd_off = CW'(1);
            RD_COUNT: rd_off = CW'(2);
            RD_INDEX: rd_off = CW'(i_read_index);
            default:  rd_off = '0;
        endcase
    end

    assign rd_sum  = (CW+1)'(r_head) + (CW+1)'(rd_off);
    assign rd_addr = (rd_sum >= (CW+1)'(BUFFER_DEPTH)) ?
                     AW'(rd_sum - (CW+1)'(BUFFER_DEPTH)) : AW'(rd_sum);

    // write position is one past the last held byte
    assign wr_sum  = (CW+1)'(r_head) + (CW+1)'(r_fill);
    assign wr_addr = (wr_sum >= (CW+1)'(BUFFER_DEPTH)) ?
                     AW'(wr_sum - (CW+1)'(BUFFER_DEPTH)) : AW'(wr_sum);

    mrff_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    // frame size from function code and byte count
    always_comb begin
        size      = '0;
        size_kind = 1'b0;
        if (r_fn == r_exp_func) begin
            if (r_exp_func == FN_READ) begin
                size = 9'(ram_rdata) + READ_OVERHEAD;
            end else if (r_exp_func == FN_WRITE) begin
                size = WRITE_LEN;
            end
        end else if (r_fn == (r_exp_func | FN_EXC_BIT)) begin
            size      = EXC_LEN;
            size_kind = 1'b1;
        end
    end

    // head pointer and fill count
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.clear) begin
            n_head = '0;
            n_fill = '0;
        end else if (i_cmd.push) begin
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.drop) begin
            n_head = (r_head == AW'(BUFFER_DEPTH - 1)) ? '0 : r_head + AW'(1);
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // held frame status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_len  <= '0;
            r_kind <= 1'b0;
        end else if (i_cmd.clear) begin
            r_done <= 1'b0;
            r_len  <= '0;
            r_kind <= 1'b0;
        end else if (i_cmd.set_frame) begin
            r_done <= 1'b1;
            r_len  <= size;
            r_kind <= size_kind;
        end
    end

    // function byte and read data capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_fn) begin
            r_fn <= ram_rdata;
        end
        if (i_cmd.zero_data) begin
            r_data <= '0;
        end else if (i_cmd.cap_data) begin
            r_data <= ram_rdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_done <= r_done;
            r_out_kind <= r_kind;
            r_out_len  <= r_len;
            r_out_data <= r_data;
        end
    end

    // status toward the controller
    assign o_status.can_push     = !r_done && (r_fill < CW'(BUFFER_DEPTH));
    assign o_status.read_ok      = r_done && (i_read_index < r_len);
    assign o_status.fill_lt_min  = r_fill < CW'(MIN_FRAME_LEN);
    assign o_status.fill_is_one  = r_fill == CW'(1);
    assign o_status.byte_match   = ram_rdata == match_addr;
    assign o_status.size_zero    = size == '0;
    assign o_status.fill_lt_size = r_fill < CW'(size);
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_frame_done   = r_out_done;
    assign o_frame_kind   = r_out_kind;
    assign o_frame_length = r_out_len;
    assign o_read_data    = r_out_data;

endmodule

[hw/rtl/mrff_ctrl.sv]
// ----------------------------------------------------------------------------
// mrff_ctrl
// Controller of the frame finder: takes one request at a time, runs the
// address hunt and frame sizing over the buffer one byte read per cycle,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module mrff_ctrl
    import mrff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [1:0] i_op,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_op    op;

    assign op = t_op'(i_op);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.rd_sel = RD_HEAD;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.zero_data = 1'b1;
                    n_state         = ST_FINISH;
                    unique case (op)
                        OP_PUSH: begin
                            if (i_status.can_push) begin
                                o_cmd.push = 1'b1;
                                n_state    = ST_SCAN_TOP;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        OP_READ: begin
                            if (i_status.read_ok) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_INDEX;
                                n_state      = ST_RD_WAIT;
                            end
                        end
                        OP_NONE: begin
                            n_state = ST_FINISH;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            // too few bytes to size a frame: stop, else look at the head
            ST_SCAN_TOP: begin
                if (i_status.fill_lt_min) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HEAD;
                    n_state      = ST_SRCH_CHK;
                end
            end
            // head byte against the slave address, dropping until it matches
            ST_SRCH_CHK: begin
                if (i_status.byte_match) begin
                    if (i_status.fill_lt_min) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_FUNC;
                        n_state      = ST_GET_FN;
                    end
                end else begin
                    o_cmd.drop = 1'b1;
                    if (i_status.fill_is_one) begin
                        n_state = ST_FINISH;
                    end else begin
                        // next head is one past the current one
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_FUNC;
                    end
                end
            end
            ST_GET_FN: begin
                o_cmd.cap_fn = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_COUNT;
                n_state      = ST_GET_CNT;
            end
            // size known: drop and rescan, wait for more bytes, or hold
            ST_GET_CNT: begin
                if (i_status.size_zero) begin
                    o_cmd.drop = 1'b1;
                    n_state    = ST_SCAN_TOP;
                end else begin
                    o_cmd.set_frame = !i_status.fill_lt_size;
                    n_state         = ST_FINISH;
                end
            end
            ST_RD_WAIT: begin
                o_cmd.cap_data = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/modbus_response_frame_finder.sv]
// ----------------------------------------------------------------------------
// modbus_response_frame_finder
// Hunts a Modbus RTU response in a stream of received bytes, sizes it by
// function code and holds it for readout by index until cleared.
// ----------------------------------------------------------------------------
// Each request (push, clear, read, or the unused code) yields exactly one
// status result. A clear, an ignored push, the unused code or a read that
// finds no byte to return goes straight to the finishing state, and a read
// of a held frame byte first waits for the registered buffer read. A push
// stops while fewer than five bytes are held. With five or more held, a
// push drops bytes while hunting the slave address, stops when the address
// turns up with fewer than five bytes left, else reads the function code
// and byte count, and after each function mismatch drops the head byte and
// rescans. The byte buffer has a single read port, which the sequencer
// walks one byte per cycle. The
// buffer is circular, so no bytes are moved when the head advances. While a
// result still waits in the output register the sequencer holds in its last
// state; a new request is taken as soon as the previous result sits in the
// output register.
// ----------------------------------------------------------------------------
module modbus_response_frame_finder
    import mrff_pkg::*;
#(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // rx_byte [7:0], read_index [16:8], zero pad
    input  logic [1:0]  i_s_tuser,   // op [1:0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // frame_length [8:0], read_data [16:9], zero pad
    output logic [1:0]  o_m_tuser,   // frame_done [0], frame_kind [1]
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       frame_done;
    logic       frame_kind;
    logic [8:0] frame_length;
    logic [7:0] read_data;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mrff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_op        (i_s_tuser),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // buffer, sizing and result register
    mrff_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_s_tdata[7:0]),
        .i_read_index   (i_s_tdata[16:8]),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_frame_done   (frame_done),
        .o_frame_kind   (frame_kind),
        .o_frame_length (frame_length),
        .o_read_data    (read_data)
    );

    // pack result fields
    assign o_m_tdata = {7'd0, read_data, frame_length};
    assign o_m_tuser = {frame_kind, frame_done};

endmodule

[hw/rtl/mrff_checker.sv]
// ----------------------------------------------------------------------------
// mrff_checker
// Port-level checks on the result channel of the frame finder, bound to
// the top level.
// ----------------------------------------------------------------------------
module mrff_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // no held frame reports zero length and normal kind
    a_idle_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser[0] |-> i_m_tdata[8:0] == 9'd0 && !i_m_tuser[1])
        else $error("status without frame carries length or kind");

    // a held frame is between five and 260 bytes long
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> i_m_tdata[8:0] >= 9'd5 && i_m_tdata[8:0] <= 9'd260)
        else $error("held frame length out of range");

    // exception replies are always five bytes
    a_exc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1] |-> i_m_tdata[8:0] == 9'd5)
        else $error("exception reply with wrong length");

    // nonzero read data only comes from a held frame
    a_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[16:9] != 8'd0 |-> i_m_tuser[0])
        else $error("read data without held frame");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

endmodule

bind modbus_response_frame_finder mrff_checker u_mrff_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
